@@ hdl/lsbp_pkg.sv @@
// Shared constants, types and codes for the log spectrum bar peak decay core.
package lsbp_pkg;

   localparam int unsigned NUM_BINS    = 256;
   localparam int unsigned MAX_COLS    = 64;
   localparam int unsigned BIN_AW      = $clog2(NUM_BINS);
   localparam int unsigned BND_DEPTH   = MAX_COLS + 1;
   localparam int unsigned BND_AW      = $clog2(BND_DEPTH);
   localparam int unsigned CNT_W       = $clog2(MAX_COLS + 1);
   localparam int unsigned COL_AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int unsigned LAST_BIN    = NUM_BINS - 1;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned KIND_W      = 1;
   localparam int unsigned INDEX_W     = 8;
   localparam int unsigned VALUE_W     = 15;
   localparam int unsigned BND_W       = 8;
   localparam int unsigned COLUMN_W    = 6;
   localparam int unsigned LEVEL_W     = 16;
   localparam int unsigned ROWS_W      = 8;
   localparam int unsigned COLS_W      = 7;
   localparam int unsigned DECAY_W     = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam int unsigned MAG_SHIFT   = 7;
   localparam int unsigned YS_W        = VALUE_W - MAG_SHIFT;
   localparam int unsigned IP_W        = $clog2(YS_W);
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned STEP_W      = $clog2(FRAC_W);
   localparam int unsigned LOG_W       = IP_W + FRAC_W;
   localparam int unsigned MANT_W      = 31;
   localparam int unsigned MANT_FB     = 30;
   localparam int unsigned SQ_W        = 2 * MANT_W;
   localparam int unsigned ROWS5_W     = ROWS_W + 3;
   localparam int unsigned PROD_W      = ROWS5_W + LOG_W;
   localparam int unsigned PROD_SHIFT  = 21;

   localparam logic [KIND_W-1:0] KIND_BOUNDARY = 1'b0;
   localparam logic [KIND_W-1:0] KIND_BIN      = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_STEP   = 2'd2;

   localparam logic [ROWS_W-1:0]  ROWS_RESET  = 8'd51;
   localparam logic [COLS_W-1:0]  COLS_RESET  = 7'd64;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd1044;

   typedef enum logic [1:0] {
      OP_BOUNDARY,
      OP_BIN,
      OP_LAST_BIN
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [INDEX_W-1:0]   addr;
      logic [VALUE_W-1:0]   data;
   } qword_type;

   typedef struct packed {
      logic [ROWS_W-1:0]    rows;
      logic [COLS_W-1:0]    cols;
      logic [DECAY_W-1:0]   decay;
   } cfg_type;

endpackage

@@ hdl/lsbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lsbp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lsbp_front.sv @@
// Front end: accepts request words, classifies them and queues them for the back end.
module lsbp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lsbp_pkg::KIND_W-1:0]   req_kind,
   input  logic [lsbp_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [lsbp_pkg::VALUE_W-1:0]  req_entry_value,
   output logic                          busy,
   input  logic                          pop,
   output logic                          head_valid,
   output lsbp_pkg::qword_type           head
);
   import lsbp_pkg::*;

   qword_type          queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   qword_type          qword;
   logic               keep;
   logic               push;
   logic               do_pop;

   always_comb begin
      qword.op   = OP_BIN;
      qword.addr = req_entry_index;
      qword.data = req_entry_value;
      keep       = 1'b0;
      case (req_kind)
         KIND_BOUNDARY: begin
            qword.op = OP_BOUNDARY;
            keep     = (32'(req_entry_index) <= MAX_COLS);
         end
         KIND_BIN: begin
            keep     = (32'(req_entry_index) < NUM_BINS);
            qword.op = (32'(req_entry_index) == LAST_BIN) ? OP_LAST_BIN : OP_BIN;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign busy       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign push       = start && !busy && keep;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= qword;
      end
   end

endmodule

@@ hdl/lsbp_back.sv @@
// Back end: stores bins and boundaries, computes and emits per-column bar levels.
module lsbp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  lsbp_pkg::cfg_type              cfg,
   input  logic                           head_valid,
   input  lsbp_pkg::qword_type            head,
   output logic                           pop,
   output logic                           rsp_strobe,
   output logic [lsbp_pkg::COLUMN_W-1:0]  rsp_column,
   output logic [lsbp_pkg::LEVEL_W-1:0]   rsp_level,
   output logic                           rsp_last_column
);
   import lsbp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LO,
      S_HI,
      S_RANGE,
      S_SCAN,
      S_LOG_INIT,
      S_LOG_STEP,
      S_MUL,
      S_LEVEL
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      col_ff, col_in;
   logic [CNT_W-1:0]      cols_ff, cols_in;
   logic [BND_W-1:0]      lo_ff, lo_in;
   logic [INDEX_W-1:0]    k_ff, k_in;
   logic [INDEX_W-1:0]    stop_ff, stop_in;
   logic                  pend_ff, pend_in;
   logic                  pend_ok_ff, pend_ok_in;
   logic [VALUE_W-1:0]    y_ff, y_in;
   logic [IP_W-1:0]       ip_ff, ip_in;
   logic [MANT_W-1:0]     x_ff, x_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [MAX_COLS-1:0]   lvl_valid_ff, lvl_valid_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [COLUMN_W-1:0]   rsp_column_ff, rsp_column_in;
   logic [LEVEL_W-1:0]    rsp_level_ff, rsp_level_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  bin_we;
   logic [BIN_AW-1:0]     bin_waddr, bin_raddr;
   logic [VALUE_W-1:0]    bin_rdata;
   logic                  bnd_we;
   logic [BND_AW-1:0]     bnd_waddr, bnd_raddr;
   logic [BND_W-1:0]      bnd_rdata;
   logic                  lvl_we;
   logic [COL_AW-1:0]     col_idx;
   logic [LEVEL_W-1:0]    lvl_rdata;

   logic [CNT_W-1:0]      cols_eff;
   logic [YS_W-1:0]       ys;
   logic [IP_W-1:0]       ip_enc;
   logic [YS_W+MANT_FB-1:0] mant_wide;
   logic [SQ_W-1:0]       sq;
   logic [MANT_W:0]       sq_top;
   logic [ROWS5_W-1:0]    rows5;
   logic [ROWS_W:0]       mag_raw;
   logic [ROWS_W-1:0]     mag;
   logic [LEVEL_W-1:0]    old_level;
   logic [LEVEL_W-1:0]    decayed;
   logic [LEVEL_W-1:0]    mag_q;
   logic [LEVEL_W-1:0]    new_level;
   logic                  last_col;

   lsbp_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_BINS)) u_bin_ram (
      .clock   (clock),
      .wr_en   (bin_we),
      .wr_addr (bin_waddr),
      .wr_data (head.data),
      .rd_addr (bin_raddr),
      .rd_data (bin_rdata)
   );

   lsbp_ram #(.WIDTH(BND_W), .DEPTH(BND_DEPTH)) u_bnd_ram (
      .clock   (clock),
      .wr_en   (bnd_we),
      .wr_addr (bnd_waddr),
      .wr_data (head.data[BND_W-1:0]),
      .rd_addr (bnd_raddr),
      .rd_data (bnd_rdata)
   );

   lsbp_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_COLS)) u_lvl_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (col_idx),
      .wr_data (new_level),
      .rd_addr (col_idx),
      .rd_data (lvl_rdata)
   );

   assign pop       = (state_ff == S_IDLE) && head_valid;
   assign bin_waddr = BIN_AW'(head.addr);
   assign bnd_waddr = BND_AW'(head.addr);
   assign col_idx   = col_ff[COL_AW-1:0];
   assign cols_eff  = (32'(cfg.cols) > MAX_COLS) ? CNT_W'(MAX_COLS) : CNT_W'(cfg.cols);
   assign ys        = y_ff[VALUE_W-1:MAG_SHIFT];
   assign mant_wide = {ys, {MANT_FB{1'b0}}} >> ip_enc;
   assign sq        = x_ff * x_ff;
   assign sq_top    = sq[SQ_W-1:MANT_FB];
   assign rows5     = {3'b000, cfg.rows} + {1'b0, cfg.rows, 2'b00};
   assign mag_raw   = prod_ff[PROD_W-1:PROD_SHIFT];
   assign mag       = (mag_raw > {1'b0, cfg.rows}) ? cfg.rows : mag_raw[ROWS_W-1:0];
   assign old_level = lvl_valid_ff[col_idx] ? lvl_rdata : '0;
   assign decayed   = (old_level > cfg.decay) ? old_level - cfg.decay : '0;
   assign mag_q     = {mag, 8'h00};
   assign new_level = (mag_q > decayed) ? mag_q : decayed;
   assign last_col  = (CNT_W'(col_ff + 1'b1) == cols_ff);

   always_comb begin
      ip_enc = '0;
      for (int b = 0; b < YS_W; b++) begin
         if (ys[b]) begin
            ip_enc = IP_W'(b);
         end
      end
   end

   always_comb begin
      logic [BND_W-1:0] hi;
      hi            = bnd_rdata;
      state_in      = state_ff;
      col_in        = col_ff;
      cols_in       = cols_ff;
      lo_in         = lo_ff;
      k_in          = k_ff;
      stop_in       = stop_ff;
      pend_in       = pend_ff;
      pend_ok_in    = pend_ok_ff;
      y_in          = y_ff;
      ip_in         = ip_ff;
      x_in          = x_ff;
      frac_in       = frac_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      lvl_valid_in  = lvl_valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_column_in = rsp_column_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_last_in   = rsp_last_ff;
      bin_we        = 1'b0;
      bnd_we        = 1'b0;
      lvl_we        = 1'b0;
      bin_raddr     = BIN_AW'(k_ff);
      bnd_raddr     = BND_AW'(col_ff);
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               case (head.op)
                  OP_BOUNDARY: begin
                     bnd_we = 1'b1;
                  end
                  OP_BIN: begin
                     bin_we = 1'b1;
                  end
                  OP_LAST_BIN: begin
                     bin_we  = 1'b1;
                     col_in  = '0;
                     cols_in = cols_eff;
                     if (cols_eff != '0) begin
                        state_in = S_LO;
                     end
                  end
                  default: begin
                     bin_we = 1'b0;
                  end
               endcase
            end
         end
         S_LO: begin
            state_in = S_HI;
         end
         S_HI: begin
            bnd_raddr = BND_AW'(col_ff + 1'b1);
            lo_in     = bnd_rdata;
            state_in  = S_RANGE;
         end
         S_RANGE: begin
            if (lo_ff == hi) begin
               k_in    = INDEX_W'(col_ff);
               stop_in = INDEX_W'(col_ff) + 1'b1;
            end else if (lo_ff < hi) begin
               k_in    = INDEX_W'(lo_ff);
               stop_in = INDEX_W'(hi);
            end else begin
               k_in    = '0;
               stop_in = '0;
            end
            y_in     = '0;
            pend_in  = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (k_ff != stop_ff) begin
               pend_in    = 1'b1;
               pend_ok_in = (32'(k_ff) < NUM_BINS);
               k_in       = k_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && pend_ok_ff && (bin_rdata > y_ff)) begin
               y_in = bin_rdata;
            end
            if ((k_ff == stop_ff) && !pend_ff) begin
               state_in = S_LOG_INIT;
            end
         end
         S_LOG_INIT: begin
            ip_in    = ip_enc;
            x_in     = MANT_W'(mant_wide);
            frac_in  = '0;
            step_in  = '0;
            state_in = (ys == '0) ? S_MUL : S_LOG_STEP;
         end
         S_LOG_STEP: begin
            frac_in = {frac_ff[FRAC_W-2:0], sq_top[MANT_W]};
            x_in    = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(FRAC_W - 1)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(rows5) * PROD_W'({ip_ff, frac_ff});
            state_in = S_LEVEL;
         end
         S_LEVEL: begin
            lvl_we                = 1'b1;
            lvl_valid_in[col_idx] = 1'b1;
            rsp_strobe_in         = 1'b1;
            rsp_column_in         = COLUMN_W'(col_ff);
            rsp_level_in          = new_level;
            rsp_last_in           = last_col;
            col_in                = col_ff + 1'b1;
            state_in              = last_col ? S_IDLE : S_LO;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         col_ff        <= '0;
         cols_ff       <= '0;
         pend_ff       <= 1'b0;
         lvl_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         cols_ff       <= cols_in;
         pend_ff       <= pend_in;
         lvl_valid_ff  <= lvl_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      lo_ff         <= lo_in;
      k_ff          <= k_in;
      stop_ff       <= stop_in;
      pend_ok_ff    <= pend_ok_in;
      y_ff          <= y_in;
      ip_ff         <= ip_in;
      x_ff          <= x_in;
      frac_ff       <= frac_in;
      step_ff       <= step_in;
      prod_ff       <= prod_in;
      rsp_column_ff <= rsp_column_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_column      = rsp_column_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_last_column = rsp_last_ff;

`ifndef SYNTHESIS
   a_strobe_from_level: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == S_LEVEL))
      else $error("result strobe without a level update");

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_last_ff) |-> (state_ff == S_IDLE))
      else $error("frame continues after its last column");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (col_ff < cols_ff))
      else $error("column counter beyond columns in use");

   a_mant_normal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOG_STEP) |-> x_ff[MANT_W-1])
      else $error("log mantissa not normalized");
`endif

endmodule

@@ hdl/log_spectrum_bar_peak_decay_core.sv @@
// Top level: configuration registers, front end queue and back end sequencer.
//
// Request channel: a word is taken at a rising edge with start high and busy low.
// req_kind 0 loads column boundary req_entry_index (0..64) with a bin number;
// req_kind 1 stores spectrum bin req_entry_index with magnitude req_entry_value.
// Words land in a four-entry queue; busy is high only while that queue is full.
// Boundary and bin words retire one a cycle while the back end is idle; a frame stalls them.
// Bin 255 closes a frame: for each column in use the back end reads two
// boundaries, scans the range one bin a cycle (a reversed range scans no bins),
// runs a 16-step log unit (skipped for a zero peak), scales and updates the
// level, all in one sequencer.
// Result channel: rsp_strobe marks each column level for exactly one cycle, in
// column order, rsp_last_column on the final one; the receiver cannot stall it.
// Configuration: csr_write_enable writes register csr_index (0 rows, 1 columns,
// 2 decay step) at once; write it only while the block is idle.
// Reset: registers return to 51 rows, 64 columns, decay 1044; all levels read
// as zero; the queue empties. Boundary and bin stores hold no reset value.
module log_spectrum_bar_peak_decay_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [lsbp_pkg::KIND_W-1:0]       req_kind,
   input  logic [lsbp_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic [lsbp_pkg::VALUE_W-1:0]      req_entry_value,
   output logic                              rsp_strobe,
   output logic [lsbp_pkg::COLUMN_W-1:0]     rsp_column,
   output logic [lsbp_pkg::LEVEL_W-1:0]      rsp_level,
   output logic                              rsp_last_column,
   input  logic                              csr_write_enable,
   input  logic [lsbp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lsbp_pkg::CSR_DATA_W-1:0]   csr_data
);
   import lsbp_pkg::*;

   logic [ROWS_W-1:0]   rows_ff, rows_in;
   logic [COLS_W-1:0]   cols_ff, cols_in;
   logic [DECAY_W-1:0]  decay_ff, decay_in;
   cfg_type             cfg;
   qword_type           head;
   logic                head_valid;
   logic                pop;

   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      decay_in = decay_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_COUNT: begin
               rows_in = csr_data[ROWS_W-1:0];
            end
            CSR_COLUMN_COUNT: begin
               cols_in = csr_data[COLS_W-1:0];
            end
            CSR_DECAY_STEP: begin
               decay_in = csr_data[DECAY_W-1:0];
            end
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= ROWS_RESET;
         cols_ff  <= COLS_RESET;
         decay_ff <= DECAY_RESET;
      end else begin
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         decay_ff <= decay_in;
      end
   end

   assign cfg.rows  = rows_ff;
   assign cfg.cols  = cols_ff;
   assign cfg.decay = decay_ff;

   lsbp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .busy            (busy),
      .pop             (pop),
      .head_valid      (head_valid),
      .head            (head)
   );

   lsbp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_column      (rsp_column),
      .rsp_level       (rsp_level),
      .rsp_last_column (rsp_last_column)
   );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for log_spectrum_bar_peak_decay_core: frames of bins in, bar levels out.
module tb_top;
   import lsbp_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned DRAIN_CYCLES   = 100;
   localparam int unsigned PHASE_WORDS    = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [LEVEL_W-1:0]  level;
      logic                last;
   } bar_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [KIND_W-1:0]      req_kind = KIND_BOUNDARY;
   logic [INDEX_W-1:0]     req_entry_index = '0;
   logic [VALUE_W-1:0]     req_entry_value = '0;
   logic                   rsp_strobe;
   logic [COLUMN_W-1:0]    rsp_column;
   logic [LEVEL_W-1:0]     rsp_level;
   logic                   rsp_last_column;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ROW_COUNT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic [VALUE_W-1:0] bins_now   [NUM_BINS];
   logic [BND_W-1:0]   bounds_now [BND_DEPTH];
   logic [LEVEL_W-1:0] levels_now [MAX_COLS];
   logic [ROWS_W-1:0]  rows_now  = ROWS_RESET;
   logic [COLS_W-1:0]  cols_now  = COLS_RESET;
   logic [DECAY_W-1:0] decay_now = DECAY_RESET;

   bar_type     bars_due[$];
   bar_type     bar_want;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned idle_pct = 0;
   int unsigned words_sent = 0;

   log_spectrum_bar_peak_decay_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_column       (rsp_column),
      .rsp_level        (rsp_level),
      .rsp_last_column  (rsp_last_column),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned log2_q16_of(input int unsigned y);
      int unsigned ip;
      int unsigned frac;
      logic [63:0] x;
      int          b;
      ip = 0;
      frac = 0;
      while ((y >> ip) > 1 && ip < 31) ip++;
      x = (64'(y) << 30) >> ip;
      for (b = 15; b >= 0; b--) begin
         x = (x * x) >> 30;
         if (x >= (64'd2 << 30)) begin
            frac |= 32'd1 << b;
            x >>= 1;
         end
      end
      return (ip << 16) | frac;
   endfunction

   function automatic int unsigned rows_for_peak(input int unsigned y);
      logic [63:0] m;
      if (y == 0) return 0;
      m = (64'd5 * 64'(rows_now) * 64'(log2_q16_of(y))) >> PROD_SHIFT;
      if (m > 64'(rows_now)) m = 64'(rows_now);
      return int'(m);
   endfunction

   // Decay and raise each bar in use, queue one level per column.
   task automatic predict_bars();
      int unsigned cols;
      int unsigned i;
      int unsigned k;
      int unsigned lo;
      int unsigned hi;
      int unsigned y;
      int unsigned lvl;
      bar_type     bar;
      cols = (cols_now > MAX_COLS) ? MAX_COLS : cols_now;
      for (i = 0; i < cols; i++) begin
         lo = bounds_now[i];
         hi = bounds_now[i + 1];
         y = 0;
         if (lo == hi) begin
            y = bins_now[i];
         end else begin
            for (k = lo; k < hi; k++) begin
               if (bins_now[k] > y) y = bins_now[k];
            end
         end
         y >>= MAG_SHIFT;
         lvl = levels_now[i];
         lvl = (lvl > decay_now) ? lvl - decay_now : 0;
         if ((rows_for_peak(y) << 8) > lvl) lvl = rows_for_peak(y) << 8;
         levels_now[i] = lvl[LEVEL_W-1:0];
         bar.column = i[COLUMN_W-1:0];
         bar.level = levels_now[i];
         bar.last = (i + 1 == cols);
         bars_due.push_back(bar);
      end
   endtask

   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                            input logic [VALUE_W-1:0] val);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_entry_index <= idx;
      req_entry_value <= val;
      do @(posedge clock); while (busy);
      if (kind == KIND_BOUNDARY) begin
         if (idx <= MAX_COLS) begin
            bounds_now[idx] = val[BND_W-1:0];
            words_sent++;
         end
      end else begin
         bins_now[idx] = val;
         words_sent++;
         if (idx == LAST_BIN) predict_bars();
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (bars_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ROW_COUNT:    rows_now = d[ROWS_W-1:0];
         CSR_COLUMN_COUNT: cols_now = d[COLS_W-1:0];
         CSR_DECAY_STEP:   decay_now = d[DECAY_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [VALUE_W-1:0] rand_magnitude();
      case ($urandom_range(3))
         0:       return VALUE_W'($urandom_range(127));
         1:       return VALUE_W'($urandom_range(32767, 16384));
         default: return VALUE_W'($urandom_range(32767));
      endcase
   endfunction

   task automatic close_frame(input logic [VALUE_W-1:0] val);
      send_word(KIND_BIN, INDEX_W'(LAST_BIN), val);
   endtask

   // Quadratically spaced boundaries over the low bins, every bin in range written,
   // first frame with reset registers.
   task automatic test_reset_frame();
      int unsigned i;
      for (i = 0; i < BND_DEPTH; i++)
         send_word(KIND_BOUNDARY, INDEX_W'(i), VALUE_W'((i * i * 63) / 4096));
      for (i = 0; i < MAX_COLS; i++) begin
         case (i)
            0:       send_word(KIND_BIN, INDEX_W'(i), 15'd0);
            1:       send_word(KIND_BIN, INDEX_W'(i), 15'h7FFF);
            2:       send_word(KIND_BIN, INDEX_W'(i), 15'd127);
            3:       send_word(KIND_BIN, INDEX_W'(i), 15'd128);
            default: send_word(KIND_BIN, INDEX_W'(i), rand_magnitude());
         endcase
      end
      close_frame(15'h7FFF);
      drain();
   endtask

   // Wide, reversed and equal-boundary ranges; boundary slots past the table.
   task automatic test_special_ranges();
      send_word(KIND_BOUNDARY, 8'd0, 15'h7F00);
      send_word(KIND_BOUNDARY, 8'd1, 15'h7F40);
      send_word(KIND_BOUNDARY, 8'd20, 15'd30);
      send_word(KIND_BOUNDARY, 8'd21, 15'h7F1E);
      send_word(KIND_BOUNDARY, 8'd65, 15'd5);
      send_word(KIND_BOUNDARY, 8'd255, 15'h7FFF);
      send_word(KIND_BIN, 8'd20, 15'h7FFF);
      send_word(KIND_BIN, 8'd100, 15'd127);
      send_word(KIND_BIN, 8'd254, 15'h7FFF);
      send_word(KIND_BIN, 8'd0, 15'd128);
      close_frame(15'd0);
      drain();
   endtask

   // Register extremes, masking of wide data and the unused index.
   task automatic test_registers();
      write_reg(CSR_ROW_COUNT, 16'h00FF);
      write_reg(CSR_DECAY_STEP, 16'h0000);
      close_frame(15'd1);
      drain();
      write_reg(CSR_ROW_COUNT, 16'hFF00);
      write_reg(CSR_DECAY_STEP, 16'hFFFF);
      close_frame(15'd2);
      drain();
      write_reg(CSR_ROW_COUNT, 16'd51);
      write_reg(CSR_DECAY_STEP, 16'd1044);
      write_reg(CSR_COLUMN_COUNT, 16'hFF80);
      write_reg(CSR_UNUSED, 16'h5A5A);
      close_frame(15'd3);
      drain();
      write_reg(CSR_COLUMN_COUNT, 16'hFFE4);
      close_frame(15'd4);
      drain();
      write_reg(CSR_COLUMN_COUNT, 16'd1);
      send_word(KIND_BIN, 8'd0, 15'h7FFF);
      close_frame(15'd5);
      drain();
      write_reg(CSR_ROW_COUNT, 16'd200);
      write_reg(CSR_COLUMN_COUNT, 16'd64);
      write_reg(CSR_DECAY_STEP, 16'd300);
      close_frame(15'd6);
      drain();
   endtask

   // Boundary values stay within 0..64 (low bins only); high bits of the value are dropped.
   task automatic send_frame();
      int unsigned n;
      int unsigned j;
      n = $urandom_range(6);
      for (j = 0; j < n; j++) begin
         case ($urandom_range(9))
            0, 1:    send_word(KIND_BOUNDARY, INDEX_W'($urandom_range(MAX_COLS)),
                               VALUE_W'(($urandom_range(127) << BND_W) |
                                        $urandom_range(MAX_COLS)));
            2:       send_word(KIND_BOUNDARY, INDEX_W'($urandom_range(255, MAX_COLS + 1)),
                               VALUE_W'($urandom_range(32767)));
            default: send_word(KIND_BIN, INDEX_W'($urandom_range(LAST_BIN - 1)),
                               rand_magnitude());
         endcase
      end
      close_frame(rand_magnitude());
   endtask

   task automatic test_random_frames();
      int unsigned idle_plan [4] = '{0, 86, 0, 27};
      int unsigned p;
      int unsigned first;
      for (p = 0; p < 4; p++) begin
         write_reg(CSR_ROW_COUNT, CSR_DATA_W'($urandom_range(255)));
         if ($urandom_range(3) == 0)
            write_reg(CSR_COLUMN_COUNT, CSR_DATA_W'($urandom_range(127, 65)));
         else
            write_reg(CSR_COLUMN_COUNT, CSR_DATA_W'($urandom_range(64, 1)));
         if ($urandom_range(1) == 0)
            write_reg(CSR_DECAY_STEP, CSR_DATA_W'($urandom_range(3000)));
         else
            write_reg(CSR_DECAY_STEP, CSR_DATA_W'($urandom_range(65535)));
         idle_pct = idle_plan[p];
         first = words_sent;
         while (words_sent - first < PHASE_WORDS) send_frame();
         idle_pct = 0;
         drain();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (bars_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected level: column %0d level 0x%04h last %0b",
                        rsp_column, rsp_level, rsp_last_column);
         end else begin
            bar_want = bars_due.pop_front();
            if (rsp_column !== bar_want.column || rsp_level !== bar_want.level ||
                rsp_last_column !== bar_want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("level mismatch: want %0d %04h %0b got %0d %04h %0b",
                           bar_want.column, bar_want.level, bar_want.last,
                           rsp_column, rsp_level, rsp_last_column);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[log_spectrum_bar_peak_decay_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < MAX_COLS; i++) levels_now[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_frame();
      test_special_ranges();
      test_registers();
      test_random_frames();
      drain();
      if (mismatches == 0) begin
         $display("[log_spectrum_bar_peak_decay_core] OK");
      end else begin
         $display("[log_spectrum_bar_peak_decay_core] ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/lsbp_pkg.sv
hdl/lsbp_ram.sv
hdl/lsbp_front.sv
hdl/lsbp_back.sv
hdl/log_spectrum_bar_peak_decay_core.sv
dv/tb_top.sv
